[rtl/pdu_pkg.sv]
// Shared constants, types and request bundles of the palette delta unpacker.
package pdu_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
    localparam int CNT_W           = IDX_W + 1;
    localparam int COMP_W          = 6;
    localparam int COLOR_W         = 3 * COMP_W;
    localparam int LEFT_W          = 10;
    localparam int COPY_W          = 7;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CMD,
        PH_INDEX,
        PH_GREEN,
        PH_RED,
        PH_CLOSED
    } phase_t;

    typedef enum logic [1:0] {
        ST_IN,
        ST_CP_READ,
        ST_CP_EMIT
    } state_t;

    typedef enum logic [1:0] {
        STAT_ENTRY = 2'd0,
        STAT_SKIP  = 2'd1,
        STAT_SHORT = 2'd2
    } stat_t;

    typedef struct packed {
        logic               snap_take;
        logic               wr_en;
        logic [IDX_W-1:0]   wr_idx;
        logic [COLOR_W-1:0] wr_data;
        logic               rd_en;
        logic [IDX_W-1:0]   rd_idx;
    } mem_req_t;

endpackage

[rtl/pdu_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module pdu_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 18
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/pdu_store.sv]
// Two-bank palette store: per-entry bank flags give the current and the snapshot palette.
module pdu_store
    import pdu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  mem_req_t           req,
    output logic [COLOR_W-1:0] rd_data
);

    // latest: bank that holds the newest value of each entry.
    // sbank: bank that held the newest value when the chunk opened.
    // svalid: entry was written at some time before the chunk opened.
    // Within a chunk every entry is written at most once and always into the
    // other bank, so the snapshot bank of an entry stays untouched.
    logic [PALETTE_ENTRIES-1:0] latest_reg, latest_next;
    logic [PALETTE_ENTRIES-1:0] sbank_reg, sbank_next;
    logic [PALETTE_ENTRIES-1:0] svalid_reg, svalid_next;
    logic                       rsel_reg, rsel_next;
    logic                       rval_reg, rval_next;
    logic                       we0, we1;
    logic [COLOR_W-1:0]         q0, q1;

    always_comb
    begin
        latest_next = latest_reg;
        sbank_next  = sbank_reg;
        svalid_next = svalid_reg;
        rsel_next   = rsel_reg;
        rval_next   = rval_reg;
        if (req.snap_take)
        begin
            sbank_next  = latest_reg;
            // Entries whose two flags differ were written during the chunk now closing.
            svalid_next = svalid_reg | (latest_reg ^ sbank_reg);
        end
        if (req.wr_en)
        begin
            latest_next[req.wr_idx] = ~sbank_reg[req.wr_idx];
        end
        if (req.rd_en)
        begin
            rsel_next = sbank_reg[req.rd_idx];
            rval_next = svalid_reg[req.rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latest_reg <= '0;
            sbank_reg  <= '0;
            svalid_reg <= '0;
            rsel_reg   <= 1'b0;
            rval_reg   <= 1'b0;
        end
        else
        begin
            latest_reg <= latest_next;
            sbank_reg  <= sbank_next;
            svalid_reg <= svalid_next;
            rsel_reg   <= rsel_next;
            rval_reg   <= rval_next;
        end
    end

    assign we0 = req.wr_en &&  sbank_reg[req.wr_idx];
    assign we1 = req.wr_en && !sbank_reg[req.wr_idx];

    pdu_ram #(
        .DEPTH (PALETTE_ENTRIES),
        .WIDTH (COLOR_W)
    ) u_bank0 (
        .clk   (clk),
        .we    (we0),
        .waddr (req.wr_idx),
        .wdata (req.wr_data),
        .re    (req.rd_en),
        .raddr (req.rd_idx),
        .rdata (q0)
    );

    pdu_ram #(
        .DEPTH (PALETTE_ENTRIES),
        .WIDTH (COLOR_W)
    ) u_bank1 (
        .clk   (clk),
        .we    (we1),
        .waddr (req.wr_idx),
        .wdata (req.wr_data),
        .re    (req.rd_en),
        .raddr (req.rd_idx),
        .rdata (q1)
    );

    // An entry never written before the chunk opened reads as zero.
    assign rd_data = rval_reg ? (rsel_reg ? q1 : q0) : '0;

    a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.wr_en && req.rd_en))
        else $error("store read and write issued in the same cycle");

    a_no_snap_during_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.snap_take && req.wr_en))
        else $error("snapshot taken while an entry is written");

    a_written_flag: assert property (@(posedge clk) disable iff (!rst_n)
        req.wr_en |=> latest_reg[$past(req.wr_idx)] != sbank_reg[$past(req.wr_idx)])
        else $error("written entry not moved off its snapshot bank");

endmodule

[rtl/pdu_ctrl.sv]
// Chunk parser and copy sequencer with the result beat register.
module pdu_ctrl
    import pdu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_byte,
    input  logic               in_start,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [IDX_W-1:0]   out_idx,
    output logic [COLOR_W-1:0] out_rgb,
    output stat_t              out_stat,
    output logic               out_done,
    output logic               out_last,
    output mem_req_t           req,
    input  logic [COLOR_W-1:0] rd_data
);

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [LEFT_W-1:0]   left_reg, left_next;
    logic [COPY_W-1:0]   copy_reg, copy_next;
    logic [IDX_W-1:0]    src_reg, src_next;
    logic [COMP_W-1:0]   blue_reg, blue_next;
    logic [COMP_W-1:0]   green_reg, green_next;

    logic                ov_reg, ov_next;
    logic [IDX_W-1:0]    oidx_reg, oidx_next;
    logic [COLOR_W-1:0]  orgb_reg, orgb_next;
    stat_t               ostat_reg, ostat_next;
    logic                odone_reg, odone_next;
    logic                olast_reg, olast_next;

    logic                out_free;
    logic                accept;
    logic                load;
    logic [LEFT_W-1:0]   left_dec;
    logic [CNT_W-1:0]    cnt_inc;
    logic [CNT_W-1:0]    skip_sum;
    logic [CNT_W-1:0]    skip_sat;
    logic                copy_end;

    assign out_free = !ov_reg || out_ready;
    assign in_ready = (state_reg == ST_IN) && out_free;
    assign accept   = in_valid && in_ready;
    assign left_dec = left_reg - LEFT_W'(1);
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign skip_sum = cnt_reg + CNT_W'(in_byte[6:0]) + CNT_W'(1);
    assign skip_sat = (skip_sum > CNT_W'(PALETTE_ENTRIES)) ? CNT_W'(PALETTE_ENTRIES)
                                                           : skip_sum;
    assign copy_end = (copy_reg == COPY_W'(1)) || (cnt_inc == CNT_W'(PALETTE_ENTRIES));

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        left_next   = left_reg;
        copy_next   = copy_reg;
        src_next    = src_reg;
        blue_next   = blue_reg;
        green_next  = green_reg;
        load        = 1'b0;
        oidx_next   = oidx_reg;
        orgb_next   = orgb_reg;
        ostat_next  = ostat_reg;
        odone_next  = odone_reg;
        olast_next  = olast_reg;
        req         = '0;

        unique case (state_reg)
            ST_IN:
            begin
                if (accept && in_start)
                begin
                    if (phase_reg != PH_IDLE && !cnt_reg[CNT_W-1])
                    begin
                        load       = 1'b1;
                        oidx_next  = cnt_reg[IDX_W-1:0];
                        orgb_next  = '0;
                        ostat_next = STAT_SHORT;
                        odone_next = 1'b0;
                        olast_next = 1'b1;
                    end
                    req.snap_take = 1'b1;
                    cnt_next      = '0;
                    copy_next     = '0;
                    blue_next     = '0;
                    green_next    = '0;
                    if (in_byte == 8'd0)
                    begin
                        left_next  = '0;
                        phase_next = PH_CLOSED;
                    end
                    else
                    begin
                        left_next  = {in_byte, 2'b00} - LEFT_W'(1);
                        phase_next = PH_CMD;
                    end
                end
                else if (accept && phase_reg != PH_IDLE && left_reg != '0)
                begin
                    left_next = left_dec;
                    case (phase_reg)
                        PH_CMD:
                        begin
                            if (in_byte[7])
                            begin
                                load       = 1'b1;
                                oidx_next  = cnt_reg[IDX_W-1:0];
                                orgb_next  = '0;
                                ostat_next = STAT_SKIP;
                                odone_next = skip_sat[CNT_W-1];
                                olast_next = 1'b1;
                                cnt_next   = skip_sat;
                                phase_next = skip_sat[CNT_W-1] ? PH_CLOSED : PH_CMD;
                            end
                            else if (in_byte[6])
                            begin
                                copy_next  = COPY_W'(in_byte[5:0]) + COPY_W'(1);
                                phase_next = PH_INDEX;
                            end
                            else
                            begin
                                blue_next  = in_byte[COMP_W-1:0];
                                phase_next = PH_GREEN;
                            end
                        end
                        PH_INDEX:
                        begin
                            src_next   = in_byte[IDX_W-1:0];
                            state_next = ST_CP_READ;
                        end
                        PH_GREEN:
                        begin
                            green_next = in_byte[COMP_W-1:0];
                            phase_next = PH_RED;
                        end
                        PH_RED:
                        begin
                            req.wr_en   = 1'b1;
                            req.wr_idx  = cnt_reg[IDX_W-1:0];
                            req.wr_data = {blue_reg, green_reg, in_byte[COMP_W-1:0]};
                            load        = 1'b1;
                            oidx_next   = cnt_reg[IDX_W-1:0];
                            orgb_next   = {blue_reg, green_reg, in_byte[COMP_W-1:0]};
                            ostat_next  = STAT_ENTRY;
                            odone_next  = cnt_inc[CNT_W-1];
                            olast_next  = 1'b1;
                            cnt_next    = cnt_inc;
                            phase_next  = cnt_inc[CNT_W-1] ? PH_CLOSED : PH_CMD;
                        end
                        default:
                        begin
                        end
                    endcase
                    // The copy decides its closing phase once all its entries are out.
                    if (left_dec == '0 && phase_reg != PH_INDEX)
                    begin
                        phase_next = PH_CLOSED;
                    end
                end
            end
            ST_CP_READ:
            begin
                req.rd_en  = 1'b1;
                req.rd_idx = src_reg;
                state_next = ST_CP_EMIT;
            end
            ST_CP_EMIT:
            begin
                if (out_free)
                begin
                    req.wr_en   = 1'b1;
                    req.wr_idx  = cnt_reg[IDX_W-1:0];
                    req.wr_data = rd_data;
                    load        = 1'b1;
                    oidx_next   = cnt_reg[IDX_W-1:0];
                    orgb_next   = rd_data;
                    ostat_next  = STAT_ENTRY;
                    odone_next  = cnt_inc[CNT_W-1];
                    olast_next  = copy_end;
                    cnt_next    = cnt_inc;
                    src_next    = src_reg + IDX_W'(1);
                    copy_next   = copy_reg - COPY_W'(1);
                    if (copy_end)
                    begin
                        copy_next  = '0;
                        state_next = ST_IN;
                        phase_next = (cnt_inc[CNT_W-1] || left_reg == '0) ? PH_CLOSED
                                                                          : PH_CMD;
                    end
                    else
                    begin
                        state_next = ST_CP_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IN;
            end
        endcase

        if (load)
        begin
            ov_next = 1'b1;
        end
        else if (out_ready)
        begin
            ov_next = 1'b0;
        end
        else
        begin
            ov_next = ov_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IN;
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            left_reg  <= '0;
            copy_reg  <= '0;
            blue_reg  <= '0;
            green_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            left_reg  <= left_next;
            copy_reg  <= copy_next;
            blue_reg  <= blue_next;
            green_reg <= green_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg   <= src_next;
        oidx_reg  <= oidx_next;
        orgb_reg  <= orgb_next;
        ostat_reg <= ostat_next;
        odone_reg <= odone_next;
        olast_reg <= olast_next;
    end

    assign out_valid = ov_reg;
    assign out_idx   = oidx_reg;
    assign out_rgb   = orgb_reg;
    assign out_stat  = ostat_reg;
    assign out_done  = odone_reg;
    assign out_last  = olast_reg;

    a_copy_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CP_EMIT |-> !cnt_reg[CNT_W-1])
        else $error("copy emitting past the last palette entry");

    a_closed_when_spent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IN && phase_reg != PH_IDLE && left_reg == '0)
        |-> phase_reg == PH_CLOSED)
        else $error("chunk bytes used up but parser still open");

    a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
        (load && odone_next) |=> cnt_reg == CNT_W'(PALETTE_ENTRIES))
        else $error("palette complete flagged before the last entry");

endmodule

[rtl/palette_delta_unpacker.sv]
// Palette delta unpacker top level: chunk parser plus two-bank palette store.
//
// Bytes of a palette chunk enter on the s_axis channel, one byte per beat;
// s_axis_tuser[0] marks the length byte that opens a chunk. Results leave on
// the m_axis channel: the entry index and its blue, green and red bytes in
// tdata, the status and the palette-complete flag in tuser, and tlast on the
// final result caused by one input byte.
// A length, skip, colour or padding byte leaves the parser ready for the next
// byte; a colour or skip result is registered and shown on the cycle after
// the byte is taken. A copy command emits its entries one at a time: a
// snapshot read in ST_CP_READ, then ST_CP_EMIT writes the entry back and
// loads the result once the result register is free, so s_axis_tready stays
// low from the index byte until the last entry is emitted. The snapshot at
// chunk start copies no data; per-entry bank flags pick the bank holding it.
// After reset no chunk is open and the palette reads as all zeros.
// A stalled receiver holds the result register, and s_axis_tready stays low
// until the waiting result beat is taken.
module palette_delta_unpacker
    import pdu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] chunk_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] entry_index, [15:8] blue, [23:16] green,
                                        // [31:24] red
    output logic [2:0]  m_axis_tuser,   // [1:0] status, [2] palette_complete
    output logic        m_axis_tlast
);

    mem_req_t           req;
    logic [COLOR_W-1:0] rd_data;
    logic [IDX_W-1:0]   out_idx;
    logic [COLOR_W-1:0] out_rgb;
    stat_t              out_stat;
    logic               out_done;

    pdu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_start  (s_axis_tuser[0]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_idx   (out_idx),
        .out_rgb   (out_rgb),
        .out_stat  (out_stat),
        .out_done  (out_done),
        .out_last  (m_axis_tlast),
        .req       (req),
        .rd_data   (rd_data)
    );

    pdu_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (rd_data)
    );

    // Each six-bit component goes out scaled by four.
    assign m_axis_tdata = {out_rgb[COMP_W-1:0], 2'b00,
                           out_rgb[2*COMP_W-1:COMP_W], 2'b00,
                           out_rgb[3*COMP_W-1:2*COMP_W], 2'b00,
                           out_idx};
    assign m_axis_tuser = {out_done, out_stat};

endmodule
